[rtl/irft_pkg.sv]
// ----------------------------------------------------------------------------
// irft_pkg
// Shared types and constants for the infrared remote frame transmitter.
// ----------------------------------------------------------------------------
package irft_pkg;

  // field widths
  localparam int TICK_W = 16;
  localparam int KEY_W  = 16;
  localparam int ADDR_W = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 3;

  // parameter defaults
  localparam int DEF_ADDRESS_BITS = 16;
  localparam int DEF_KEY_BITS     = 16;
  localparam int DEF_COPIES       = 2;

  // register reset values
  localparam logic [CFG_W-1:0] RST_HEADER_MARK  = 16'd4443;
  localparam logic [CFG_W-1:0] RST_HEADER_SPACE = 16'd4569;
  localparam logic [CFG_W-1:0] RST_BIT_MARK     = 16'd492;
  localparam logic [CFG_W-1:0] RST_ONE_SPACE    = 16'd1749;
  localparam logic [CFG_W-1:0] RST_ZERO_SPACE   = 16'd630;
  localparam logic [CFG_W-1:0] RST_STOP_SPACE   = 16'd590;
  localparam logic [CFG_W-1:0] RST_REPEAT_GAP   = 16'd52000;
  localparam logic [CFG_W-1:0] RST_ADDRESS      = 16'hE0E0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPACE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS      = 3'd7;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // input word
  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key_code;
  } irft_req_t;

  // result word
  typedef struct packed {
    logic ir_mark;
    logic led_on;
    logic busy_res;
    logic done_res;
  } irft_rsp_t;

endpackage

[rtl/ir_remote_frame_transmitter.sv]
// ----------------------------------------------------------------------------
// ir_remote_frame_transmitter
// Pulse-distance infrared frame envelope generator with repeated copies.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries start words (req_type = start, key_code) and
//   one-microsecond tick words. A start is taken only while idle and then
//   loads the frame {address register, key}; starts while busy are ignored.
//   Ticks walk through header mark/space, a mark and one/zero space per bit
//   (MSB first), stop mark/space, and a repeat gap between copies.
//   Every input word yields exactly one result word showing the emitter
//   level, LED, busy and a done pulse on the word that ends the last copy.
//   Phases of zero length are skipped within the same word.
//   Results are registered, valid in the cycle after accept; one word per
//   cycle unless stalled, set by the single registered state update.
//   The result register lets a new word in whenever it is empty or being
//   taken; while the receiver stalls, in_ready drops and nothing is lost.
//   Configuration writes take effect in the cycle after cfg_we; lengths
//   apply when a phase is next entered, the address at the next start.
//   Synchronous reset returns to idle, restores register defaults and
//   empties the result register.
// ----------------------------------------------------------------------------
module ir_remote_frame_transmitter
  import irft_pkg::*;
#(
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  parameter int KEY_BITS     = DEF_KEY_BITS,
  parameter int COPIES       = DEF_COPIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  irft_req_t            in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output irft_rsp_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int FRAME_BITS = ADDRESS_BITS + KEY_BITS;
  localparam int BW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int CW = (COPIES > 1) ? $clog2(COPIES) : 1;
  localparam logic [BW-1:0] TOP_BIT  = BW'(FRAME_BITS - 1);
  localparam logic [CW-1:0] LAST_CPY = CW'(COPIES - 1);

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_HMARK  = 8'b0000_0010,
    PH_HSPACE = 8'b0000_0100,
    PH_BMARK  = 8'b0000_1000,
    PH_BSPACE = 8'b0001_0000,
    PH_SMARK  = 8'b0010_0000,
    PH_SSPACE = 8'b0100_0000,
    PH_GAP    = 8'b1000_0000
  } phase_t;

  // phase being entered by the current word
  typedef enum logic [2:0] {
    EN_NONE, EN_HMARK, EN_HSPACE, EN_BMARK, EN_BSPACE, EN_SMARK, EN_SSPACE, EN_END
  } entry_t;

  // configuration registers
  logic [CFG_W-1:0] header_mark_ticks, header_space_ticks, bit_mark_ticks;
  logic [CFG_W-1:0] one_space_ticks, zero_space_ticks, stop_space_ticks;
  logic [CFG_W-1:0] repeat_gap_ticks, address_word;

  // sequencer state
  phase_t            phase, phase_next;
  logic [TICK_W-1:0] ticks_left, ticks_left_next;
  logic [BW-1:0]     bit_position, bit_position_next;
  logic [FRAME_BITS-1:0] frame_word, frame_word_next;
  logic [CW-1:0]     second_copy, second_copy_next;
  logic              done_next;

  logic in_fire;
  logic [FRAME_BITS-1:0] frame_new, frame_eff, space_nz;
  entry_t        entry;
  logic [BW-1:0] entry_bit, search_lim;
  logic [CW-1:0] copy_eff;
  logic          part_hit, full_hit;
  logic [BW-1:0] part_pos, full_pos;

  logic hm_nz, hs_nz, bm_nz, os_nz, zs_nz, ss_nz, gp_nz;

  // first non-empty phase of a fresh frame
  phase_t            head_phase;
  logic [TICK_W-1:0] head_ticks;
  logic [BW-1:0]     head_bit;
  logic              head_found;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_ticks  <= RST_HEADER_MARK;
      header_space_ticks <= RST_HEADER_SPACE;
      bit_mark_ticks     <= RST_BIT_MARK;
      one_space_ticks    <= RST_ONE_SPACE;
      zero_space_ticks   <= RST_ZERO_SPACE;
      stop_space_ticks   <= RST_STOP_SPACE;
      repeat_gap_ticks   <= RST_REPEAT_GAP;
      address_word       <= RST_ADDRESS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_MARK:  header_mark_ticks  <= cfg_data;
        REG_HEADER_SPACE: header_space_ticks <= cfg_data;
        REG_BIT_MARK:     bit_mark_ticks     <= cfg_data;
        REG_ONE_SPACE:    one_space_ticks    <= cfg_data;
        REG_ZERO_SPACE:   zero_space_ticks   <= cfg_data;
        REG_STOP_SPACE:   stop_space_ticks   <= cfg_data;
        REG_REPEAT_GAP:   repeat_gap_ticks   <= cfg_data;
        REG_ADDRESS:      address_word       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hm_nz = (header_mark_ticks != '0);
  assign hs_nz = (header_space_ticks != '0);
  assign bm_nz = (bit_mark_ticks != '0);
  assign os_nz = (one_space_ticks != '0);
  assign zs_nz = (zero_space_ticks != '0);
  assign ss_nz = (stop_space_ticks != '0);
  assign gp_nz = (repeat_gap_ticks != '0);

  // frame assembly: address above key, unused upper bits zero
  for (genvar gi = 0; gi < FRAME_BITS; gi++) begin : g_frame
    if (gi < KEY_BITS) begin : g_key
      if (gi < KEY_W) begin : g_kb
        assign frame_new[gi] = in_data.key_code[gi];
      end else begin : g_kz
        assign frame_new[gi] = 1'b0;
      end
    end else begin : g_addr
      if (gi - KEY_BITS < ADDR_W) begin : g_ab
        assign frame_new[gi] = address_word[gi - KEY_BITS];
      end else begin : g_az
        assign frame_new[gi] = 1'b0;
      end
    end
  end

  // decode which phase the word enters
  always_comb begin
    entry     = EN_NONE;
    entry_bit = bit_position;
    frame_eff = frame_word;
    copy_eff  = second_copy;
    if (in_data.req_type == REQ_START) begin
      if (phase == PH_IDLE) begin
        entry     = EN_HMARK;
        frame_eff = frame_new;
        copy_eff  = '0;
      end
    end else if (phase != PH_IDLE && ticks_left <= TICK_W'(1)) begin
      case (phase)
        PH_HMARK: entry = EN_HSPACE;
        PH_HSPACE: begin
          entry     = EN_BMARK;
          entry_bit = TOP_BIT;
        end
        PH_BMARK: entry = EN_BSPACE;
        PH_BSPACE: begin
          if (bit_position == '0) begin
            entry = EN_SMARK;
          end else begin
            entry     = EN_BMARK;
            entry_bit = bit_position - BW'(1);
          end
        end
        PH_SMARK:  entry = EN_SSPACE;
        PH_SSPACE: entry = EN_END;
        PH_GAP:    entry = EN_HMARK;
        default:   entry = EN_NONE;
      endcase
    end
    if (entry == EN_HSPACE) begin
      entry_bit = TOP_BIT;
    end
  end

  // bits whose space phase has a nonzero length
  always_comb begin
    for (int i = 0; i < FRAME_BITS; i++) begin
      space_nz[i] = frame_eff[i] ? os_nz : zs_nz;
    end
  end

  assign search_lim = (entry == EN_BSPACE) ? entry_bit - BW'(1) : entry_bit;

  irft_bit_search #(.WIDTH(FRAME_BITS), .IDXW(BW)) u_part_search (
    .word  (space_nz),
    .limit (search_lim),
    .hit   (part_hit),
    .pos   (part_pos)
  );

  irft_bit_search #(.WIDTH(FRAME_BITS), .IDXW(BW)) u_full_search (
    .word  (space_nz),
    .limit (TOP_BIT),
    .hit   (full_hit),
    .pos   (full_pos)
  );

  // first phase of a frame that is not skipped
  always_comb begin
    head_found = 1'b1;
    head_bit   = TOP_BIT;
    head_phase = PH_IDLE;
    head_ticks = '0;
    if (hm_nz) begin
      head_phase = PH_HMARK;
      head_ticks = header_mark_ticks;
    end else if (hs_nz) begin
      head_phase = PH_HSPACE;
      head_ticks = header_space_ticks;
    end else if (bm_nz) begin
      head_phase = PH_BMARK;
      head_ticks = bit_mark_ticks;
    end else if (full_hit) begin
      head_phase = PH_BSPACE;
      head_bit   = full_pos;
      head_ticks = frame_eff[full_pos] ? one_space_ticks : zero_space_ticks;
    end else if (ss_nz) begin
      head_phase = PH_SSPACE;
      head_ticks = stop_space_ticks;
    end else begin
      head_found = 1'b0;
    end
  end

  // next state: fall through empty phases in frame order
  always_comb begin
    logic try_bm, try_sm, try_ss, try_end;
    try_bm  = (entry == EN_BMARK);
    try_sm  = (entry == EN_SMARK);
    try_ss  = (entry == EN_SSPACE);
    try_end = (entry == EN_END);

    phase_next        = phase;
    ticks_left_next   = ticks_left;
    bit_position_next = bit_position;
    frame_word_next   = frame_word;
    second_copy_next  = copy_eff;
    done_next         = 1'b0;

    if (in_data.req_type == REQ_START && phase == PH_IDLE) begin
      frame_word_next   = frame_new;
      bit_position_next = '0;
    end
    if (in_data.req_type == REQ_TICK && phase != PH_IDLE &&
        ticks_left > TICK_W'(1)) begin
      ticks_left_next = ticks_left - TICK_W'(1);
    end

    // header mark entered
    if (entry == EN_HMARK) begin
      if (head_found) begin
        phase_next        = head_phase;
        ticks_left_next   = head_ticks;
        bit_position_next = head_bit;
      end else begin
        try_end = 1'b1;
      end
    end

    // header space entered
    if (entry == EN_HSPACE) begin
      if (hs_nz) begin
        phase_next      = PH_HSPACE;
        ticks_left_next = header_space_ticks;
      end else begin
        try_bm = 1'b1;
      end
    end

    // data space entered
    if (entry == EN_BSPACE) begin
      if (space_nz[entry_bit]) begin
        phase_next        = PH_BSPACE;
        bit_position_next = entry_bit;
        ticks_left_next   = frame_eff[entry_bit] ? one_space_ticks : zero_space_ticks;
      end else if (entry_bit == '0) begin
        try_sm = 1'b1;
      end else begin
        try_bm = 1'b1;
      end
    end

    // data mark entered at search_lim
    if (try_bm) begin
      if (bm_nz) begin
        phase_next        = PH_BMARK;
        ticks_left_next   = bit_mark_ticks;
        bit_position_next = search_lim;
      end else if (part_hit) begin
        phase_next        = PH_BSPACE;
        bit_position_next = part_pos;
        ticks_left_next   = frame_eff[part_pos] ? one_space_ticks : zero_space_ticks;
      end else begin
        try_ss = 1'b1;
      end
    end

    // stop mark
    if (try_sm) begin
      if (bm_nz) begin
        phase_next      = PH_SMARK;
        ticks_left_next = bit_mark_ticks;
      end else begin
        try_ss = 1'b1;
      end
    end

    // stop space
    if (try_ss) begin
      if (ss_nz) begin
        phase_next      = PH_SSPACE;
        ticks_left_next = stop_space_ticks;
      end else begin
        try_end = 1'b1;
      end
    end

    // copy finished
    if (try_end) begin
      if (copy_eff == LAST_CPY) begin
        phase_next      = PH_IDLE;
        ticks_left_next = '0;
        done_next       = 1'b1;
      end else begin
        second_copy_next = copy_eff + CW'(1);
        if (gp_nz) begin
          phase_next      = PH_GAP;
          ticks_left_next = repeat_gap_ticks;
        end else if (head_found) begin
          phase_next        = head_phase;
          ticks_left_next   = head_ticks;
          bit_position_next = head_bit;
        end else begin
          // every remaining copy is empty
          phase_next      = PH_IDLE;
          ticks_left_next = '0;
          done_next       = 1'b1;
        end
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      ticks_left   <= '0;
      bit_position <= '0;
      frame_word   <= '0;
      second_copy  <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      ticks_left   <= ticks_left_next;
      bit_position <= bit_position_next;
      frame_word   <= frame_word_next;
      second_copy  <= second_copy_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.ir_mark  <= (phase_next == PH_HMARK) || (phase_next == PH_BMARK) ||
                           (phase_next == PH_SMARK);
      out_data.led_on   <= (phase_next != PH_IDLE);
      out_data.busy_res <= (phase_next != PH_IDLE);
      out_data.done_res <= done_next;
    end
  end

endmodule

[rtl/irft_bit_search.sv]
// ----------------------------------------------------------------------------
// irft_bit_search
// Finds the highest set bit of a word at or below a given bit position.
// ----------------------------------------------------------------------------
module irft_bit_search #(
  parameter int WIDTH = 32,
  parameter int IDXW  = 5
) (
  input  logic [WIDTH-1:0] word,
  input  logic [IDXW-1:0]  limit,
  output logic             hit,
  output logic [IDXW-1:0]  pos
);

  // priority encode, highest qualifying bit wins
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (word[i] && (IDXW'(i) <= limit)) begin
        hit = 1'b1;
        pos = IDXW'(i);
      end
    end
  end

endmodule

[rtl/irft_checker.sv]
// ----------------------------------------------------------------------------
// irft_checker
// Port-level checks for the infrared remote frame transmitter.
// ----------------------------------------------------------------------------
module irft_checker
  import irft_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input irft_rsp_t out_data
);

  // every accepted word gives a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result word after accept");

  // a stalled result blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // done ends the transmission
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |->
      !out_data.busy_res && !out_data.ir_mark && !out_data.led_on)
    else $error("done with transmission still active");

  // emitter only fires during a transmission
  a_mark_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ir_mark |-> out_data.busy_res && out_data.led_on)
    else $error("mark outside a transmission");

endmodule

bind ir_remote_frame_transmitter irft_checker u_irft_checker (.*);

[sim/tb_ir_remote_frame_transmitter.sv]
// ----------------------------------------------------------------------------
// tb_ir_remote_frame_transmitter
// Self-checking bench for the infrared remote frame transmitter. A directed
// table walks the idle state after reset, all-zero and minimal lengths and an
// all-ones frame, then random tick/start traffic runs under several idle and
// stall mixes. Each result is checked against a typed row or in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ir_remote_frame_transmitter;
  import irft_pkg::*;

  localparam int FRAME_W = DEF_ADDRESS_BITS + DEF_KEY_BITS;

  // transmitter phases as seen by the predictor
  typedef enum logic [2:0] {
    S_IDLE, S_HDR_MARK, S_HDR_SPACE, S_BIT_MARK,
    S_BIT_SPACE, S_STOP_MARK, S_STOP_SPACE, S_GAP
  } tx_state_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    irft_req_t            word;
    logic                 typed;
    irft_rsp_t            rsp;
  } dir_row_t;

  localparam irft_req_t W_TICK = '{REQ_TICK, 16'h0000};
  localparam irft_rsp_t RSP_IDLE = 4'b0000;
  localparam irft_rsp_t RSP_MARK = 4'b1110;
  localparam irft_rsp_t RSP_DONE = 4'b0001;

  localparam int DIR_ROWS = 34;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // idle tick after reset
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b1, RSP_IDLE},
    // every length zero: the start word itself finishes both copies
    '{ROW_CFG, REG_HEADER_MARK, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_HEADER_SPACE, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_BIT_MARK, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_ONE_SPACE, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_ZERO_SPACE, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_STOP_SPACE, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_REPEAT_GAP, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_ADDRESS, 16'hFFFF, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, '{REQ_START, 16'hA5A5}, 1'b1, RSP_DONE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b1, RSP_IDLE},
    // minimal lengths, no repeat gap: start, ignored start, ticks
    '{ROW_CFG, REG_HEADER_MARK, 16'd1, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_HEADER_SPACE, 16'd1, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_BIT_MARK, 16'd1, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_ONE_SPACE, 16'd2, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_ZERO_SPACE, 16'd1, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_STOP_SPACE, 16'd1, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_REPEAT_GAP, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_CFG, REG_ADDRESS, 16'h0000, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, '{REQ_START, 16'h8001}, 1'b1, RSP_MARK},
    '{ROW_WORD, 3'd0, 16'd0, '{REQ_START, 16'h0000}, 1'b1, RSP_MARK},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    // all-ones frame
    '{ROW_CFG, REG_ADDRESS, 16'hFFFF, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, '{REQ_START, 16'hFFFF}, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE},
    '{ROW_WORD, 3'd0, 16'd0, W_TICK, 1'b0, RSP_IDLE}
  };

  // idle mixes: sender idle percent, receiver stall percent
  localparam int SEND_IDLE [4] = '{0, 77, 0, 32};
  localparam int RECV_STALL [4] = '{0, 0, 77, 32};

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  irft_req_t            in_data;
  logic                 out_valid;
  logic                 out_ready;
  irft_rsp_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int sender_idle_pct;
  int recv_stall_pct;
  int err_cnt;
  int hold_trigger;
  int hold_seen;
  int hold_left;

  // typed expectation for directed rows
  logic      typed_valid;
  irft_rsp_t typed_rsp;

  irft_rsp_t pending_rsp [$];

  // predictor state and register copy
  tx_state_t          tx_st;
  logic [TICK_W-1:0]  ticks_left;
  int                 bit_idx;
  logic [FRAME_W-1:0] frame_bits;
  int                 copies_done;
  logic               done_flag;
  logic [CFG_W-1:0]   cfg_regs [8];

  ir_remote_frame_transmitter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // length of the phase just entered
  function automatic logic [TICK_W-1:0] phase_len();
    case (tx_st)
      S_HDR_MARK:   return cfg_regs[REG_HEADER_MARK];
      S_HDR_SPACE:  return cfg_regs[REG_HEADER_SPACE];
      S_BIT_MARK:   return cfg_regs[REG_BIT_MARK];
      S_BIT_SPACE:  return frame_bits[bit_idx] ? cfg_regs[REG_ONE_SPACE]
                                               : cfg_regs[REG_ZERO_SPACE];
      S_STOP_MARK:  return cfg_regs[REG_BIT_MARK];
      S_STOP_SPACE: return cfg_regs[REG_STOP_SPACE];
      S_GAP:        return cfg_regs[REG_REPEAT_GAP];
      default:      return '0;
    endcase
  endfunction

  function automatic void advance_phase();
    case (tx_st)
      S_HDR_MARK: tx_st = S_HDR_SPACE;
      S_HDR_SPACE: begin
        bit_idx = FRAME_W - 1;
        tx_st = S_BIT_MARK;
      end
      S_BIT_MARK: tx_st = S_BIT_SPACE;
      S_BIT_SPACE: begin
        if (bit_idx == 0) begin
          tx_st = S_STOP_MARK;
        end else begin
          bit_idx--;
          tx_st = S_BIT_MARK;
        end
      end
      S_STOP_MARK: tx_st = S_STOP_SPACE;
      S_STOP_SPACE: begin
        copies_done++;
        if (copies_done >= DEF_COPIES) begin
          tx_st = S_IDLE;
          done_flag = 1'b1;
        end else begin
          tx_st = S_GAP;
        end
      end
      S_GAP: tx_st = S_HDR_MARK;
      default: tx_st = S_IDLE;
    endcase
  endfunction

  // load the phase length, skipping zero-length phases
  function automatic void load_phase();
    while (1) begin
      if (tx_st == S_IDLE) begin
        ticks_left = '0;
        return;
      end
      ticks_left = phase_len();
      if (ticks_left != '0) return;
      advance_phase();
    end
  endfunction

  function automatic irft_rsp_t predict_envelope(irft_req_t w);
    irft_rsp_t r;
    done_flag = 1'b0;
    if (w.req_type == REQ_START) begin
      if (tx_st == S_IDLE) begin
        frame_bits = {cfg_regs[REG_ADDRESS], w.key_code};
        copies_done = 0;
        bit_idx = 0;
        tx_st = S_HDR_MARK;
        load_phase();
      end
    end else if (tx_st != S_IDLE) begin
      if (ticks_left != '0) ticks_left--;
      if (ticks_left == '0) begin
        advance_phase();
        load_phase();
      end
    end
    r.ir_mark  = (tx_st == S_HDR_MARK || tx_st == S_BIT_MARK || tx_st == S_STOP_MARK);
    r.led_on   = (tx_st != S_IDLE);
    r.busy_res = (tx_st != S_IDLE);
    r.done_res = done_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic e, logic a);
    if (a !== e) begin
      err_cnt++;
      $display("%0t mismatch %s: expected %b, actual %b", $time, name, e, a);
    end
  endfunction

  // result check, predictor update and register copy
  always @(posedge clk) begin
    irft_rsp_t exp_rsp;
    irft_rsp_t pred;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected result word: expected none, actual %b",
                   $time, out_data);
        end else begin
          exp_rsp = pending_rsp.pop_front();
          check_field("ir_mark", exp_rsp.ir_mark, out_data.ir_mark);
          check_field("led_on", exp_rsp.led_on, out_data.led_on);
          check_field("busy_res", exp_rsp.busy_res, out_data.busy_res);
          check_field("done_res", exp_rsp.done_res, out_data.done_res);
        end
      end
      if (in_valid && in_ready) begin
        pred = predict_envelope(in_data);
        pending_rsp.push_back(typed_valid ? typed_rsp : pred);
      end
      if (cfg_we) cfg_regs[cfg_index] = cfg_data;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input irft_req_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop offering words until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // tick until the transmission in progress has ended
  task automatic finish_frame();
    while (tx_st != S_IDLE) send_word(W_TICK);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // run limit
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    irft_req_t        w;
    logic [CFG_W-1:0] len;
    int               sel;

    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    err_cnt = 0;
    hold_trigger = 0;
    hold_seen = 0;
    hold_left = 0;
    typed_valid = 1'b0;
    typed_rsp = '0;

    tx_st = S_IDLE;
    ticks_left = '0;
    bit_idx = 0;
    frame_bits = '0;
    copies_done = 0;
    done_flag = 1'b0;
    cfg_regs[REG_HEADER_MARK]  = RST_HEADER_MARK;
    cfg_regs[REG_HEADER_SPACE] = RST_HEADER_SPACE;
    cfg_regs[REG_BIT_MARK]     = RST_BIT_MARK;
    cfg_regs[REG_ONE_SPACE]    = RST_ONE_SPACE;
    cfg_regs[REG_ZERO_SPACE]   = RST_ZERO_SPACE;
    cfg_regs[REG_STOP_SPACE]   = RST_STOP_SPACE;
    cfg_regs[REG_REPEAT_GAP]   = RST_REPEAT_GAP;
    cfg_regs[REG_ADDRESS]      = RST_ADDRESS;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        finish_frame();
        wait_drained();
        cfg_write(DIR_TABLE[i].idx, DIR_TABLE[i].val);
      end else begin
        typed_valid = DIR_TABLE[i].typed;
        typed_rsp   = DIR_TABLE[i].rsp;
        send_word(DIR_TABLE[i].word);
        typed_valid = 1'b0;
      end
    end

    // random traffic, two register settings per idle mix
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = SEND_IDLE[ph];
      recv_stall_pct  = RECV_STALL[ph];
      for (int blk = 0; blk < 2; blk++) begin
        wait_drained();
        for (int r = 0; r < 8; r++) begin
          sel = $urandom_range(99);
          if (r == REG_ADDRESS) len = CFG_W'($urandom_range(16'hFFFF));
          else if (sel < 30) len = '0;
          else if (sel < 85) len = CFG_W'(1);
          else len = CFG_W'($urandom_range(3, 2));
          cfg_write(r[CFG_IDX_W-1:0], len);
        end
        for (int n = 0; n < 64; n++) begin
          // long receiver hold while words keep coming
          if (ph == 0 && blk == 1 && n == 20) hold_trigger++;
          // sender pause until every result is back
          if (ph == 1 && blk == 0 && n == 40) wait_drained();
          w.req_type = ($urandom_range(99) < 8) ? REQ_START : REQ_TICK;
          w.key_code = KEY_W'($urandom_range(16'hFFFF));
          send_word(w);
        end
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (pending_rsp.size() != 0) begin
      err_cnt++;
      $display("%0t results missing: expected %0d more, actual 0", $time,
               pending_rsp.size());
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
